[rtl/core/assert_macros.svh]
// Assertion macros for the test signal generator core.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define TSG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle.
`define TSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tsg_pkg.sv]
// Shared types, constants and helpers for the test signal generator core.
// No dependencies.
package tsg_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int FRAC            = SAMPLE_BITS - 1;
	localparam int CHANNELS        = 8;
	localparam int CH_W            = 3;
	localparam int PINK_ROWS       = 16;
	localparam int PINK_SHIFT      = 5;              // log2(2 * PINK_ROWS)
	localparam int ROW_W           = $clog2(PINK_ROWS);
	localparam int TOTAL_W         = SAMPLE_BITS + ROW_W;
	localparam int SINE_TABLE_BITS = 10;
	localparam int QB              = SINE_TABLE_BITS - 2;
	localparam int CFG_W           = 32;
	localparam int IDX_W           = 3;
	localparam int GAIN_W          = 20;

	localparam logic [31:0] LCG_A = 32'd1664525;
	localparam logic [31:0] LCG_C = 32'd1013904223;
	localparam logic [31:0] SEED_RESET = 32'h9E3779B9;
	localparam logic [31:0] BROWN_STEP = 32'd1311;

	localparam logic [63:0] SIN_A32 = 64'd6746518852;
	localparam logic [63:0] SIN_B32 = 64'd2755619465;
	localparam logic [63:0] SIN_C32 = 64'd304067908;
	localparam logic [SAMPLE_BITS-1:0] SIN_A = SAMPLE_BITS'(SIN_A32 >> (32 - FRAC));
	localparam logic [SAMPLE_BITS-1:0] SIN_B = SAMPLE_BITS'(SIN_B32 >> (32 - FRAC));
	localparam logic [SAMPLE_BITS-1:0] SIN_C = SAMPLE_BITS'(SIN_C32 >> (32 - FRAC));

	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [IDX_W-1:0] {
		REG_WAVEFORM = 3'd0,
		REG_MIX_MODE = 3'd1,
		REG_GAIN     = 3'd2,
		REG_BASE_INC = 3'd3,
		REG_FACTOR   = 3'd4,
		REG_SAMPLES  = 3'd5,
		REG_MASK     = 3'd6,
		REG_SEED     = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		WF_OFF   = 3'd0,
		WF_SINE  = 3'd1,
		WF_SWEEP = 3'd2,
		WF_WHITE = 3'd3,
		WF_PINK  = 3'd4,
		WF_BROWN = 3'd5
	} waveform_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LCG,
		S_NOISE,
		S_PINK,
		S_BROWN_M,
		S_BROWN,
		S_SIN_X2,
		S_SIN_C,
		S_SIN_T,
		S_SIN_Y,
		S_SIN_END,
		S_SWEEP,
		S_SWEEP2,
		S_GAIN,
		S_GAIN2,
		S_MIX
	} state_t;

	typedef struct packed {
		logic [2:0]             waveform;
		logic                   mix_mode;
		logic [GAIN_W-1:0]      gain;
		logic [31:0]            base_inc;
		logic [31:0]            factor;
		logic [23:0]            samples;
		logic [CHANNELS-1:0]    mask;
		logic [31:0]            seed;
	} cfg_t;

	typedef struct packed {
		logic ld_base;
		logic ld_seed;
	} cfg_evt_t;

	// Saturate a one-bit-grown sum back to sample width.
	function automatic logic signed [SAMPLE_BITS-1:0] sat1(
		input logic signed [SAMPLE_BITS:0] v);
		if (v > $signed({SMAX[SAMPLE_BITS-1], SMAX}))
			return SMAX;
		else if (v < $signed({SMIN[SAMPLE_BITS-1], SMIN}))
			return SMIN;
		else
			return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

[rtl/core/tsg_mul.sv]
// Shared 32x32 unsigned multiplier with a registered product.
// Does not use tsg_pkg; no other dependencies.
module tsg_mul (
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [63:0] prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(op_a) * 64'(op_b);
	end

	assign prod = prod_q;

endmodule

[rtl/core/tsg_cfg.sv]
// Configuration register file of the test signal generator core.
// Depends on tsg_pkg for the register indexes and the cfg_t / cfg_evt_t structs.
module tsg_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tsg_pkg::IDX_W-1:0]   cfg_index,
	input  logic [tsg_pkg::CFG_W-1:0]   cfg_data,
	output tsg_pkg::cfg_t               cfg,
	output tsg_pkg::cfg_evt_t           evt
);

	tsg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.waveform <= tsg_pkg::WF_OFF;
			cfg_q.mix_mode <= 1'b0;
			cfg_q.gain     <= 20'd65536;
			cfg_q.base_inc <= 32'd0;
			cfg_q.factor   <= 32'd1073741824;
			cfg_q.samples  <= 24'd48000;
			cfg_q.mask     <= '0;
			cfg_q.seed     <= tsg_pkg::SEED_RESET;
		end else if (cfg_we) begin
			unique case (tsg_pkg::reg_idx_t'(cfg_index))
				tsg_pkg::REG_WAVEFORM: cfg_q.waveform <= cfg_data[2:0];
				tsg_pkg::REG_MIX_MODE: cfg_q.mix_mode <= cfg_data[0];
				tsg_pkg::REG_GAIN:     cfg_q.gain     <= cfg_data[tsg_pkg::GAIN_W-1:0];
				tsg_pkg::REG_BASE_INC: cfg_q.base_inc <= cfg_data;
				tsg_pkg::REG_FACTOR:   cfg_q.factor   <= cfg_data;
				tsg_pkg::REG_SAMPLES:  cfg_q.samples  <= cfg_data[23:0];
				tsg_pkg::REG_MASK:     cfg_q.mask     <= cfg_data[tsg_pkg::CHANNELS-1:0];
				tsg_pkg::REG_SEED:     cfg_q.seed     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
	assign evt.ld_base = cfg_we && (tsg_pkg::reg_idx_t'(cfg_index) == tsg_pkg::REG_BASE_INC);
	assign evt.ld_seed = cfg_we && (tsg_pkg::reg_idx_t'(cfg_index) == tsg_pkg::REG_SEED);

endmodule

[rtl/core/test_signal_generator_core.sv]
// Top level of the test signal generator: sequencer, generator state and mixer.
// Depends on tsg_pkg, tsg_cfg, tsg_mul and assert_macros.svh.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+----------------------------------
//  input     | in        | in_valid / in_ready  | channel, frame_start, in_sample
//  output    | out       | out_valid / out_ready| out_channel, out_sample
//  config    | in        | cfg_we               | cfg_index, cfg_data
//
// Sequence: a request that does not advance the generator goes straight to the mixer
//   step; one that does first runs its chain of products (noise, pink, brown, sine or
//   sweep, then gain) through the one shared 32x32 multiplier.
// Reset: arst_n clears control and generator state at once; no clearing pass.
// Stalls: a finished result sits in the output register; the next request is
//   taken while it waits, and the mixer holds until the output register frees.
`include "assert_macros.svh"

module test_signal_generator_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [tsg_pkg::IDX_W-1:0]              cfg_index,
	input  logic [tsg_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [tsg_pkg::CH_W-1:0]               channel,
	input  logic                                   frame_start,
	input  logic signed [tsg_pkg::SAMPLE_BITS-1:0] in_sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [tsg_pkg::CH_W-1:0]               out_channel,
	output logic signed [tsg_pkg::SAMPLE_BITS-1:0] out_sample
);

	localparam int SB = tsg_pkg::SAMPLE_BITS;
	localparam int F  = tsg_pkg::FRAC;

	tsg_pkg::cfg_t     cfg;
	tsg_pkg::cfg_evt_t evt;

	tsg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.evt       (evt)
	);

	// Shared multiplier: operands picked by state, product ready next cycle.
	logic [31:0] mul_a, mul_b;
	logic [63:0] p_q;

	tsg_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (p_q)
	);

	tsg_pkg::state_t state_q, state_d;

	// Latched request.
	logic [tsg_pkg::CH_W-1:0]      ch_q;
	logic signed [SB-1:0]          x_q;
	logic                          sel_q;

	// Generator state.
	logic [31:0]                   lcg_q;
	logic signed [SB-1:0]          rows_q [tsg_pkg::PINK_ROWS];
	logic signed [tsg_pkg::TOTAL_W-1:0] total_q;
	logic signed [SB-1:0]          brown_q;
	logic [31:0]                   phase_q;
	logic [31:0]                   step_q;
	logic [23:0]                   count_q;
	logic signed [SB-1:0]          held_q;

	// Scratch.
	logic signed [SB-1:0]          w_q;
	logic [SB-1:0]                 x2_q;
	logic signed [SB+1:0]          gsrc_q;

	// Output register.
	logic                          out_valid_q;
	logic [tsg_pkg::CH_W-1:0]      out_channel_q;
	logic signed [SB-1:0]          out_sample_q;

	logic accept, active, gen;
	assign accept = in_valid && in_ready;
	assign active = (cfg.waveform >= tsg_pkg::WF_SINE) && (cfg.waveform <= tsg_pkg::WF_BROWN)
		&& (cfg.mask != '0);
	assign gen = active && frame_start;

	// Sine angle: top table bits of the phase, folded into the first quadrant.
	logic [tsg_pkg::SINE_TABLE_BITS-1:0] idx;
	logic [1:0]                          quad;
	logic [tsg_pkg::QB:0]                pos;
	logic [SB-1:0]                       sx;
	assign idx  = phase_q[31 -: tsg_pkg::SINE_TABLE_BITS];
	assign quad = idx[tsg_pkg::SINE_TABLE_BITS-1 -: 2];
	assign pos  = quad[0] ? ((tsg_pkg::QB+1)'(1) << tsg_pkg::QB) - {1'b0, idx[tsg_pkg::QB-1:0]}
		: {1'b0, idx[tsg_pkg::QB-1:0]};
	assign sx   = {pos, {(F - tsg_pkg::QB){1'b0}}};

	logic [SB-1:0] p_hi;
	assign p_hi = p_q[F +: SB];

	// Noise step from the product of the LCG multiply.
	logic [31:0]          lcg_new;
	logic signed [SB-1:0] white;
	logic [tsg_pkg::ROW_W-1:0] row_k;
	logic signed [tsg_pkg::TOTAL_W-1:0] total_new;
	assign lcg_new = p_q[31:0] + tsg_pkg::LCG_C;
	assign white   = {~lcg_new[31], lcg_new[30:32-SB]};

	always_comb begin
		row_k = tsg_pkg::ROW_W'(tsg_pkg::PINK_ROWS - 1);
		for (int i = tsg_pkg::PINK_ROWS - 2; i >= 0; i--) begin
			if (lcg_new[i])
				row_k = tsg_pkg::ROW_W'(i);
		end
	end

	assign total_new = total_q + tsg_pkg::TOTAL_W'(white) - tsg_pkg::TOTAL_W'(rows_q[row_k]);

	// Pink output: total * 3 / (2 * rows), truncated toward zero.
	logic signed [tsg_pkg::TOTAL_W+1:0] pink3;
	logic signed [tsg_pkg::TOTAL_W+1:0] pink_q;
	assign pink3  = (tsg_pkg::TOTAL_W+2)'(total_q) + ((tsg_pkg::TOTAL_W+2)'(total_q) <<< 1);
	assign pink_q = $signed(pink3 + (pink3[tsg_pkg::TOTAL_W+1]
		? (tsg_pkg::TOTAL_W+2)'((1 << tsg_pkg::PINK_SHIFT) - 1) : '0)) >>> tsg_pkg::PINK_SHIFT;

	// Brown step, sign restored on the magnitude product.
	logic signed [SB-1:0] bstep;
	logic [SB-1:0]        w_mag;
	logic signed [SB-1:0] brown_new;
	assign w_mag = w_q[SB-1] ? SB'(-w_q) : SB'(w_q);
	assign bstep = w_q[SB-1] ? -$signed(p_q[16 +: SB]) : $signed(p_q[16 +: SB]);
	assign brown_new = tsg_pkg::sat1((SB+1)'(brown_q) + (SB+1)'(bstep));

	// Sine result clamp.
	logic [SB:0]          sy;
	logic signed [SB-1:0] sy_c;
	assign sy   = p_q[F +: SB+1];
	assign sy_c = (sy > (SB+1)'(tsg_pkg::SMAX)) ? tsg_pkg::SMAX : $signed(sy[SB-1:0]);

	// Sweep bookkeeping.
	logic [23:0] cnt1;
	logic        restart;
	assign cnt1    = count_q + 24'd1;
	assign restart = (cnt1 >= cfg.samples);

	// Gain stage: magnitude times gain, shift, re-sign, saturate.
	logic [SB+1:0]          g_mag;
	logic signed [32:0]     g_sh;
	logic signed [SB-1:0]   g_out;
	assign g_mag = gsrc_q[SB+1] ? (SB+2)'(-gsrc_q) : (SB+2)'(gsrc_q);
	assign g_sh  = gsrc_q[SB+1] ? -$signed({1'b0, p_q[16 +: 32]}) : $signed({1'b0, p_q[16 +: 32]});
	assign g_out = (g_sh > 33'(tsg_pkg::SMAX)) ? tsg_pkg::SMAX
		: (g_sh < 33'(tsg_pkg::SMIN)) ? tsg_pkg::SMIN : g_sh[SB-1:0];

	// Mixer.
	logic signed [SB-1:0] mix_out;
	assign mix_out = !sel_q ? x_q : cfg.mix_mode ? held_q
		: tsg_pkg::sat1((SB+1)'(x_q) + (SB+1)'(held_q));

	// Multiplier operand select.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			tsg_pkg::S_LCG:     begin mul_a = lcg_q;            mul_b = tsg_pkg::LCG_A;       end
			tsg_pkg::S_SIN_X2:  begin mul_a = 32'(sx);          mul_b = 32'(sx);              end
			tsg_pkg::S_SIN_C:   begin mul_a = 32'(p_hi);        mul_b = 32'(tsg_pkg::SIN_C);  end
			tsg_pkg::S_SIN_T:   begin mul_a = 32'(x2_q);        mul_b = 32'(tsg_pkg::SIN_B - p_hi); end
			tsg_pkg::S_SIN_Y:   begin mul_a = 32'(sx);          mul_b = 32'(tsg_pkg::SIN_A - p_hi); end
			tsg_pkg::S_SWEEP:   begin mul_a = step_q;           mul_b = cfg.factor;           end
			tsg_pkg::S_BROWN_M: begin mul_a = 32'(w_mag);       mul_b = tsg_pkg::BROWN_STEP;  end
			tsg_pkg::S_GAIN:    begin mul_a = 32'(g_mag);       mul_b = 32'(cfg.gain);        end
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsg_pkg::S_IDLE: begin
				if (accept) begin
					if (!gen)
						state_d = tsg_pkg::S_MIX;
					else if (cfg.waveform == tsg_pkg::WF_SINE || cfg.waveform == tsg_pkg::WF_SWEEP)
						state_d = tsg_pkg::S_SIN_X2;
					else
						state_d = tsg_pkg::S_LCG;
				end
			end
			tsg_pkg::S_LCG:     state_d = tsg_pkg::S_NOISE;
			tsg_pkg::S_NOISE: begin
				priority case (cfg.waveform)
					tsg_pkg::WF_PINK:  state_d = tsg_pkg::S_PINK;
					tsg_pkg::WF_BROWN: state_d = tsg_pkg::S_BROWN_M;
					default:           state_d = tsg_pkg::S_GAIN;
				endcase
			end
			tsg_pkg::S_PINK:    state_d = tsg_pkg::S_GAIN;
			tsg_pkg::S_BROWN_M: state_d = tsg_pkg::S_BROWN;
			tsg_pkg::S_BROWN:   state_d = tsg_pkg::S_GAIN;
			tsg_pkg::S_SIN_X2:  state_d = tsg_pkg::S_SIN_C;
			tsg_pkg::S_SIN_C:   state_d = tsg_pkg::S_SIN_T;
			tsg_pkg::S_SIN_T:   state_d = tsg_pkg::S_SIN_Y;
			tsg_pkg::S_SIN_Y:   state_d = tsg_pkg::S_SIN_END;
			tsg_pkg::S_SIN_END: state_d = (cfg.waveform == tsg_pkg::WF_SWEEP)
				? tsg_pkg::S_SWEEP : tsg_pkg::S_GAIN;
			tsg_pkg::S_SWEEP:   state_d = restart ? tsg_pkg::S_GAIN : tsg_pkg::S_SWEEP2;
			tsg_pkg::S_SWEEP2:  state_d = tsg_pkg::S_GAIN;
			tsg_pkg::S_GAIN:    state_d = tsg_pkg::S_GAIN2;
			tsg_pkg::S_GAIN2:   state_d = tsg_pkg::S_MIX;
			tsg_pkg::S_MIX:     state_d = (!out_valid_q || out_ready) ? tsg_pkg::S_IDLE
				: tsg_pkg::S_MIX;
			default:            state_d = tsg_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready = (state_q == tsg_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tsg_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// Request latch; payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q  <= channel;
			x_q   <= in_sample;
			sel_q <= active && (32'(channel) < tsg_pkg::CHANNELS)
				&& cfg.mask[channel[$clog2(tsg_pkg::CHANNELS)-1:0]];
		end
		if (state_q == tsg_pkg::S_NOISE) begin
			w_q    <= white;
			gsrc_q <= (SB+2)'(white);
		end
		if (state_q == tsg_pkg::S_PINK)
			gsrc_q <= (SB+2)'(pink_q);
		// Feed the new walk level to the gain step.
		if (state_q == tsg_pkg::S_BROWN)
			gsrc_q <= (SB+2)'(brown_new);
		if (state_q == tsg_pkg::S_SIN_C)
			x2_q <= p_hi;
		if (state_q == tsg_pkg::S_SIN_END)
			gsrc_q <= (SB+2)'(quad[1] ? -sy_c : sy_c);
	end

	// Generator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q   <= tsg_pkg::SEED_RESET;
			for (int i = 0; i < tsg_pkg::PINK_ROWS; i++)
				rows_q[i] <= '0;
			total_q <= '0;
			brown_q <= '0;
			phase_q <= '0;
			step_q  <= '0;
			count_q <= '0;
			held_q  <= '0;
		end else begin
			unique case (state_q)
				tsg_pkg::S_NOISE: begin
					lcg_q <= lcg_new;
					if (cfg.waveform == tsg_pkg::WF_PINK) begin
						rows_q[row_k] <= white;
						total_q       <= total_new;
					end
				end
				tsg_pkg::S_BROWN: begin
					brown_q <= brown_new;
				end
				tsg_pkg::S_SIN_END: begin
					// Advance the phase with the step in force for this sample.
					phase_q <= phase_q + ((cfg.waveform == tsg_pkg::WF_SWEEP) ? step_q : cfg.base_inc);
				end
				tsg_pkg::S_SWEEP: begin
					if (restart) begin
						count_q <= '0;
						step_q  <= cfg.base_inc;
					end else begin
						count_q <= cnt1;
					end
				end
				tsg_pkg::S_SWEEP2: begin
					// Saturate the step times the Q2.30 factor back to 32 bits.
					step_q <= (p_q[63:62] != 2'b00) ? 32'hFFFFFFFF : p_q[61:30];
				end
				tsg_pkg::S_GAIN2: held_q <= g_out;
				default: ;
			endcase
			if (evt.ld_seed)
				lcg_q <= cfg_data;
			if (evt.ld_base) begin
				step_q  <= cfg_data;
				count_q <= '0;
			end
		end
	end

	// Brown walk update marker: registered, high in the cycle after S_BROWN.
	logic brown_src_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			brown_src_q <= 1'b0;
		else
			brown_src_q <= (state_q == tsg_pkg::S_BROWN);
	end

	// Output register: hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (state_q == tsg_pkg::S_MIX && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tsg_pkg::S_MIX && (!out_valid_q || out_ready)) begin
			out_channel_q <= ch_q;
			out_sample_q  <= mix_out;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign out_sample  = out_sample_q;

	`TSG_ASSERT_NEXT(a_pass_to_mix, accept && !gen, state_q == tsg_pkg::S_MIX,
		"request without generation did not go to the mixer")
	`TSG_ASSERT_NEXT(a_gain_chain, state_q == tsg_pkg::S_GAIN, state_q == tsg_pkg::S_GAIN2,
		"gain product not taken")
	`TSG_ASSERT_SAME(a_load_from_mix, $rose(out_valid_q), $past(state_q == tsg_pkg::S_MIX),
		"output loaded outside the mixer step")
	`TSG_ASSERT_SAME(a_brown_src, brown_src_q, state_q == tsg_pkg::S_GAIN,
		"brown level not followed by the gain step")

endmodule

[verif/testbench.sv]
// Self-checking testbench for test_signal_generator_core: drives channel-sample requests,
// predicts every output sample in a local model and compares them field by field.
// Depends on tsg_pkg and the RTL of test_signal_generator_core.
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic [tsg_pkg::CH_W-1:0]        ch;
		logic [tsg_pkg::SAMPLE_BITS-1:0] smp;
	} sample_rec_t;

	localparam longint S_HI = (longint'(1) << tsg_pkg::FRAC) - 1;
	localparam longint S_LO = -(longint'(1) << tsg_pkg::FRAC);

	logic                                   clk;
	logic                                   arst_n;
	logic                                   cfg_we;
	logic [tsg_pkg::IDX_W-1:0]              cfg_index;
	logic [tsg_pkg::CFG_W-1:0]              cfg_data;
	logic                                   in_valid;
	logic                                   in_ready;
	logic [tsg_pkg::CH_W-1:0]               channel;
	logic                                   frame_start;
	logic signed [tsg_pkg::SAMPLE_BITS-1:0] in_sample;
	logic                                   out_valid;
	logic                                   out_ready;
	logic [tsg_pkg::CH_W-1:0]               out_channel;
	logic signed [tsg_pkg::SAMPLE_BITS-1:0] out_sample;

	// expected output samples, oldest first
	sample_rec_t mixed_q[$];
	int          fails;
	bit          quiet;    // set for the closing stretch: no idling on either side
	int          rx_hold;

	// local copy of the configuration
	logic [2:0]  m_wave;
	logic        m_replace;
	logic [19:0] m_gain;
	logic [31:0] m_base, m_factor, m_seed;
	logic [23:0] m_len;
	logic [7:0]  m_mask;

	// local copy of the generator state
	logic [31:0] lcg, acc, step;
	logic [23:0] scount;
	longint      rows [tsg_pkg::PINK_ROWS];
	longint      pink_sum, brown, held;

	test_signal_generator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.channel(channel), .frame_start(frame_start), .in_sample(in_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_channel(out_channel), .out_sample(out_sample)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Bound the run well beyond the slowest legal schedule.
	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint sat_sample(longint v);
		if (v > S_HI)
			return S_HI;
		if (v < S_LO)
			return S_LO;
		return v;
	endfunction

	function automatic longint scale_by_gain(longint s);
		return sat_sample((s * longint'({44'd0, m_gain})) / 65536);
	endfunction

	// Quarter-wave polynomial sine, mirrored per quadrant.
	function automatic longint sine_at(logic [31:0] ph);
		logic [9:0]  idx;
		logic [1:0]  quad;
		logic [63:0] pos, x, x2, t, y, a, b, c;
		idx  = ph[31:22];
		quad = idx[9:8];
		pos  = {56'd0, idx[7:0]};
		a    = 64'd6746518852 >> 9;
		b    = 64'd2755619465 >> 9;
		c    = 64'd304067908 >> 9;
		if (quad[0])
			pos = 64'd256 - pos;
		x  = pos << 15;
		x2 = (x * x) >> tsg_pkg::FRAC;
		t  = b - ((x2 * c) >> tsg_pkg::FRAC);
		t  = a - ((x2 * t) >> tsg_pkg::FRAC);
		y  = (x * t) >> tsg_pkg::FRAC;
		if (y > 64'(S_HI))
			y = 64'(S_HI);
		return quad[1] ? -longint'(y) : longint'(y);
	endfunction

	// Advance the noise LCG and return the centered white sample.
	function automatic longint next_white();
		lcg = lcg * tsg_pkg::LCG_A + tsg_pkg::LCG_C;
		return longint'({40'd0, lcg[31:8]}) - (longint'(1) << tsg_pkg::FRAC);
	endfunction

	// Produce the next held sample for the current waveform.
	function automatic longint advance_tone();
		longint      w;
		int          k;
		logic [63:0] p;
		case (m_wave)
			tsg_pkg::WF_WHITE: return scale_by_gain(next_white());
			tsg_pkg::WF_PINK: begin
				w = next_white();
				k = 0;
				while (k < tsg_pkg::PINK_ROWS - 1 && !lcg[k])
					k++;
				pink_sum += w - rows[k];
				rows[k] = w;
				return scale_by_gain((pink_sum * 3) / (2 * tsg_pkg::PINK_ROWS));
			end
			tsg_pkg::WF_BROWN: begin
				w = next_white();
				brown = sat_sample(brown + (w * 1311) / 65536);
				return scale_by_gain(brown);
			end
			tsg_pkg::WF_SINE: begin
				w = sine_at(acc);
				acc += m_base;
				return scale_by_gain(w);
			end
			default: begin
				w = sine_at(acc);
				acc += step;
				scount = scount + 24'd1;
				if (scount >= m_len) begin
					scount = '0;
					step = m_base;
				end else begin
					p = ({32'd0, step} * {32'd0, m_factor}) >> 30;
					step = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
				end
				return scale_by_gain(w);
			end
		endcase
	endfunction

	// Work out the output sample for one accepted request.
	function automatic logic [tsg_pkg::SAMPLE_BITS-1:0] mix_sample(
			logic [tsg_pkg::CH_W-1:0] ch, logic fs,
			logic signed [tsg_pkg::SAMPLE_BITS-1:0] s);
		longint x, y;
		x = longint'(s);
		y = x;
		if (m_wave >= tsg_pkg::WF_SINE && m_wave <= tsg_pkg::WF_BROWN && m_mask != 0) begin
			if (fs)
				held = advance_tone();
			if (m_mask[ch])
				y = m_replace ? held : sat_sample(x + held);
		end
		return y[tsg_pkg::SAMPLE_BITS-1:0];
	endfunction

	function automatic void model_reset();
		m_wave = tsg_pkg::WF_OFF; m_replace = 1'b0; m_gain = 20'd65536; m_base = '0;
		m_factor = 32'd1073741824; m_len = 24'd48000; m_mask = '0;
		m_seed = tsg_pkg::SEED_RESET;
		lcg = tsg_pkg::SEED_RESET; acc = '0; step = '0; scount = '0;
		foreach (rows[i])
			rows[i] = 0;
		pink_sum = 0; brown = 0; held = 0;
	endfunction

	// Write one register; the caller makes sure the block is idle.
	task automatic cfg_write(tsg_pkg::reg_idx_t idx, logic [31:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		case (idx)
			tsg_pkg::REG_WAVEFORM: m_wave = d[2:0];
			tsg_pkg::REG_MIX_MODE: m_replace = d[0];
			tsg_pkg::REG_GAIN:     m_gain = d[19:0];
			tsg_pkg::REG_BASE_INC: begin
				m_base = d; step = d; scount = '0;
			end
			tsg_pkg::REG_FACTOR:   m_factor = d;
			tsg_pkg::REG_SAMPLES:  m_len = d[23:0];
			tsg_pkg::REG_MASK:     m_mask = d[7:0];
			tsg_pkg::REG_SEED: begin
				m_seed = d; lcg = d;
			end
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Drop the request line, hold until every expected sample has drained,
	// then let the sequencer settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (mixed_q.size() != 0)
			@(negedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Send one request; called and returning at a rising edge.
	task automatic send_item(logic [tsg_pkg::CH_W-1:0] ch, logic fs,
			logic [tsg_pkg::SAMPLE_BITS-1:0] s);
		sample_rec_t rec;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		channel     <= ch;
		frame_start <= fs;
		in_sample   <= s;
		// ready seen at the falling edge means the request goes at the next rising edge
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		rec.ch  = ch;
		rec.smp = mix_sample(ch, fs, s);
		mixed_q.push_back(rec);
	endtask

	// One frame of sequential channels, the first carrying frame_start.
	task automatic send_frame(int n);
		for (int c = 0; c < n; c++)
			send_item(c[tsg_pkg::CH_W-1:0], c == 0, tsg_pkg::SAMPLE_BITS'($urandom));
	endtask

	// Receiver: stall in random bursts, none in the closing stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold   <= 0;
		end else if (quiet) begin
			out_ready <= 1'b1;
		end else if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold   <= rx_hold - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			out_ready <= 1'b0;
			rx_hold   <= $urandom_range(0, 3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Check each sample at the falling edge before the edge that takes it.
	always @(negedge clk) begin
		sample_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (mixed_q.size() == 0) begin
				$error("out_sample: no request pending, got channel %0d sample %0d",
					out_channel, out_sample);
				fails++;
			end else begin
				want = mixed_q.pop_front();
				if (out_channel !== want.ch) begin
					$error("out_channel: expected %0d, actual %0d", want.ch, out_channel);
					fails++;
				end
				if (out_sample !== want.smp) begin
					$error("out_sample: expected %0d, actual %0d",
						$signed(want.smp), out_sample);
					fails++;
				end
			end
		end
	end

	// Reset defaults: generator off, every sample passes through.
	task automatic test_reset_state();
		send_item(3'd0, 1'b1, 24'h7FFFFF);
		send_item(3'd7, 1'b0, 24'h800000);
		drain();
		// mask on but waveform still off
		cfg_write(tsg_pkg::REG_MASK, 32'hFF);
		cfg_write(tsg_pkg::REG_MIX_MODE, 32'd1);
		send_item(3'd1, 1'b1, 24'h123456);
		drain();
	endtask

	// Each waveform once, replace and add, extremes of gain and samples.
	task automatic test_waveforms();
		cfg_write(tsg_pkg::REG_MASK, 32'hA5);
		cfg_write(tsg_pkg::REG_BASE_INC, 32'h0123_4567);
		for (int w = tsg_pkg::WF_SINE; w <= tsg_pkg::WF_BROWN; w++) begin
			cfg_write(tsg_pkg::REG_WAVEFORM, w);
			cfg_write(tsg_pkg::REG_MIX_MODE, w & 1);
			cfg_write(tsg_pkg::REG_GAIN, (w == tsg_pkg::WF_BROWN) ? 32'hFFFFF : 32'd65536);
			send_item(3'd2, 1'b0, 24'h000001);   // before any frame start
			send_item(3'd0, 1'b1, 24'h7FFFFF);
			send_item(3'd5, 1'b0, 24'h800000);
			send_item(3'd7, 1'b0, 24'h7FFFFF);
			drain();
		end
		// zero gain and unused waveform codes
		cfg_write(tsg_pkg::REG_GAIN, 32'd0);
		send_item(3'd0, 1'b1, 24'h7FFFFF);
		drain();
		cfg_write(tsg_pkg::REG_WAVEFORM, 32'd6);
		send_item(3'd0, 1'b1, 24'h400000);
		drain();
		cfg_write(tsg_pkg::REG_WAVEFORM, 32'd7);
		send_item(3'd2, 1'b1, 24'hC00000);
		drain();
	endtask

	// Sweep step saturation, zero length, and register side effects.
	task automatic test_sweep_edges();
		cfg_write(tsg_pkg::REG_WAVEFORM, 32'(tsg_pkg::WF_SWEEP));
		cfg_write(tsg_pkg::REG_GAIN, 32'd65536);
		cfg_write(tsg_pkg::REG_FACTOR, 32'hFFFF_FFFF);
		cfg_write(tsg_pkg::REG_SAMPLES, 32'hFF_FFFF);
		cfg_write(tsg_pkg::REG_BASE_INC, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++)
			send_item(3'd0, 1'b1, 24'd0);
		drain();
		cfg_write(tsg_pkg::REG_SAMPLES, 32'd0);
		cfg_write(tsg_pkg::REG_FACTOR, 32'd0);
		for (int i = 0; i < 3; i++)
			send_item(3'd0, 1'b1, 24'd0);
		drain();
		// seed reloads restart the white sequence from a new value; empty mask freezes everything
		cfg_write(tsg_pkg::REG_WAVEFORM, 32'(tsg_pkg::WF_WHITE));
		cfg_write(tsg_pkg::REG_SEED, 32'd0);
		send_item(3'd0, 1'b1, 24'd0);
		drain();
		cfg_write(tsg_pkg::REG_SEED, 32'hFFFF_FFFF);
		cfg_write(tsg_pkg::REG_MASK, 32'd0);
		send_item(3'd0, 1'b1, 24'h55AAAA);
		drain();
	endtask

	// Random phase: random settings, then mostly well-formed frames.
	task automatic random_phase(int n_items, logic [2:0] wf);
		int sent, len;
		cfg_write(tsg_pkg::REG_WAVEFORM, 32'(wf));
		cfg_write(tsg_pkg::REG_MIX_MODE, $urandom_range(0, 1));
		cfg_write(tsg_pkg::REG_GAIN,
			($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 131072));
		cfg_write(tsg_pkg::REG_BASE_INC, $urandom);
		cfg_write(tsg_pkg::REG_FACTOR, 32'h3FF0_0000 + $urandom_range(0, 32'h0020_0000));
		cfg_write(tsg_pkg::REG_SAMPLES, $urandom_range(0, 300));
		cfg_write(tsg_pkg::REG_MASK,
			($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 255));
		if ($urandom_range(0, 1))
			cfg_write(tsg_pkg::REG_SEED, $urandom);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: arbitrary channel and frame flag
				send_item(tsg_pkg::CH_W'($urandom), 1'($urandom),
					tsg_pkg::SAMPLE_BITS'($urandom));
				sent++;
			end else begin
				len = $urandom_range(1, tsg_pkg::CHANNELS);
				send_frame(len);
				sent += len;
			end
			// around the middle of each phase, hold off until the block has fully drained
			if (sent > n_items / 2 && sent <= n_items / 2 + tsg_pkg::CHANNELS)
				drain();
		end
		drain();
	endtask

	task automatic test_random();
		for (int p = 0; p < 8; p++)
			random_phase(200, 3'($urandom_range(0, 7)));
		quiet = 1'b1;
		random_phase(250, tsg_pkg::WF_PINK);
	endtask

	initial begin
		fails       = 0;
		quiet       = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		channel     = '0;
		frame_start = 1'b0;
		in_sample   = '0;
		model_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_waveforms();
		test_sweep_edges();
		test_random();
		drain();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
